### hdl/adam_pkg.sv
`timescale 1ns / 1ps
package adam_pkg;

  localparam int unsigned SLOT_FIELD_W = 12;

  localparam logic [23:0] LEARN_RATE_RESET   = 24'd16777;
  localparam logic [15:0] FIRST_DECAY_RESET  = 16'd58982;
  localparam logic [15:0] SECOND_DECAY_RESET = 16'd65470;
  localparam logic [31:0] DENOM_GUARD_RESET  = 32'd43;

  localparam logic [31:0] POWER_ONE  = 32'hFFFF_FFFF;
  localparam logic [16:0] DECAY_ONE  = 17'h1_0000;
  localparam logic [32:0] UNIT_Q32   = 33'h1_0000_0000;
  localparam logic [40:0] STEP_LIMIT = 41'h100_0000_0000;
  localparam logic [47:0] VHAT_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MHAT_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT  = 32'h8000_0000;

  localparam logic [5:0] DIV_M_LAST = 6'd31;
  localparam logic [5:0] DIV_V_LAST = 6'd47;
  localparam logic [5:0] DIV_S_LAST = 6'd40;
  localparam logic [5:0] SQRT_LAST  = 6'd31;
  localparam logic [3:0] REDUCE_TOP = 4'd11;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_DIV_M,
    ST_DIV_V,
    ST_SQRT,
    ST_DIV_S,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_POW1,
    OP_POW2,
    OP_M_OLD,
    OP_M_GRAD,
    OP_G_SQ,
    OP_V_LO,
    OP_V_HI,
    OP_G2_LO,
    OP_G2_HI,
    OP_STEP
  } op_t;

  typedef enum logic [1:0] {
    REG_LEARN_RATE,
    REG_FIRST_DECAY,
    REG_SECOND_DECAY,
    REG_DENOM_GUARD
  } reg_index_t;

  typedef enum logic {
    ACT_UPDATE,
    ACT_CLEAR
  } action_t;

endpackage

### hdl/adam_item_if.sv
`timescale 1ns / 1ps
interface adam_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        first_of_call;
  logic [11:0] slot_address;
  logic [31:0] param_value;
  logic [31:0] grad_value;

  modport source (output valid, action, first_of_call, slot_address, param_value, grad_value,
                  input ready);
  modport sink (input valid, action, first_of_call, slot_address, param_value, grad_value,
                output ready);
endinterface

### hdl/adam_result_if.sv
`timescale 1ns / 1ps
interface adam_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_param;
  logic        saturated;

  modport source (output valid, new_param, saturated, input ready);
  modport sink (input valid, new_param, saturated, output ready);
endinterface

### hdl/adam_cfg_if.sv
`timescale 1ns / 1ps
interface adam_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/adam_optimizer_update_core.sv
`timescale 1ns / 1ps
// Element-wise Adam update engine, fixed point.
// item:   one request per element (param, grad, slot), or a clear request that drops
//         all moments and restarts the step count.
// result: one updated parameter plus saturation flag per update request; a clear
//         request gives no result.
// cfg:    register writes (learn rate, decays, epsilon); always ready, write only
//         while the engine is idle.
// An update's duration is set by the shared restoring divider (32-, 48- and 41-bit
//   quotients for m_hat, v_hat and the step) and the bit-serial square root (32-bit
//   root); products go through one 32x32 multiplier, each in a multiply and an
//   accumulate state. first_of_call adds the two step-power products to an update.
// Throughput: one request at a time; item.ready is high only while idle.
// Reset and clear requests: the slot valid bits are swept to zero, one slot per
//   cycle, over all SLOTS slots; item.ready stays low meanwhile. Registers return to
//   their defaults on reset only.
// A finished result waits in the output register while the receiver stalls; the
//   next request is taken meanwhile, and its result waits for the register.
module adam_optimizer_update_core #(
  parameter int unsigned SLOTS = 4096
) (
  input  logic   clk,
  input  logic   rst,
  adam_item_if.sink     item,
  adam_result_if.source result,
  adam_cfg_if.sink      cfg
);
  import adam_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_t state, state_next;
  op_t    op;

  logic [23:0] learn_rate;
  logic [15:0] first_decay;
  logic [15:0] second_decay;
  logic [31:0] denom_guard;
  logic [31:0] pow1, pow2;

  logic [79:0] moment_mem [SLOTS];
  logic        valid_mem  [SLOTS];
  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] slot;
  logic [79:0]   rd_word;
  logic          rd_valid;

  logic [11:0] red_val;
  logic [3:0]  red_k;
  logic [32:0] slots_sh;
  logic [31:0] param, grad;

  logic [31:0] mul_a, mul_b;
  logic        op_neg, op_shift, op_fresh;
  logic [63:0] prod;
  logic [67:0] acc, acc_sum, addend;

  logic [31:0] m_cur;
  logic [47:0] v_cur;
  logic [46:0] g2;
  logic [31:0] m_old, g_abs, m_abs, mabs;
  logic [47:0] v_old;
  logic        m_neg;
  logic [32:0] d1, d2;

  logic [40:0] dv_rem, dv_den;
  logic [63:0] dv_num;
  logic [47:0] dv_q, dv_q_next;
  logic [41:0] dv_t;
  logic        dv_ge, dv_ovf;
  logic [5:0]  cnt;

  logic [63:0] sq_x, sq_res, sq_bit, sq_trial, sq_res_next;
  logic [47:0] vhat;
  logic [40:0] den, den_calc;
  logic [63:0] step_num;

  logic [40:0] step;
  logic [42:0] res_wide;
  logic [31:0] hold_param;
  logic        hold_sat;
  logic        out_valid;
  logic [31:0] out_param;
  logic        out_sat;

  logic        item_fire;

  assign item_fire = item.valid && item.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == AW'(SLOTS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (item_fire) state_next = (action_t'(item.action) == ACT_CLEAR) ? ST_CLEAR : ST_REDUCE;
      end
      ST_REDUCE: if (red_k == '0) state_next = ST_READ;
      ST_READ:   state_next = ST_MUL;
      ST_MUL:    state_next = ST_ACC;
      ST_ACC: begin
        if (op == OP_G2_HI) state_next = ST_DIV_M;
        else if (op == OP_STEP) state_next = ST_DIV_S;
        else state_next = ST_MUL;
      end
      ST_DIV_M: if (cnt == '0) state_next = ST_DIV_V;
      ST_DIV_V: if (cnt == '0) state_next = ST_SQRT;
      ST_SQRT:  if (cnt == '0) state_next = ST_MUL;
      ST_DIV_S: if (cnt == '0) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || result.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and operand selection
  always_comb begin
    item.ready       = (state == ST_IDLE);
    cfg.ready        = 1'b1;
    result.valid     = out_valid;
    result.new_param = out_param;
    result.saturated = out_sat;

    m_old = rd_valid ? rd_word[79:48] : '0;
    v_old = rd_valid ? rd_word[47:0]  : '0;
    g_abs = grad[31] ? (32'd0 - grad) : grad;
    m_neg = m_cur[31];
    m_abs = m_neg ? (32'd0 - m_cur) : m_cur;
    d1    = UNIT_Q32 - {1'b0, pow1};
    d2    = UNIT_Q32 - {1'b0, pow2};

    mul_a    = '0;
    mul_b    = '0;
    op_neg   = 1'b0;
    op_shift = 1'b0;
    op_fresh = 1'b0;
    unique case (op)
      OP_POW1: begin mul_a = pow1; mul_b = {16'd0, first_decay}; end
      OP_POW2: begin mul_a = pow2; mul_b = {16'd0, second_decay}; end
      OP_M_OLD: begin
        mul_a    = m_old[31] ? (32'd0 - m_old) : m_old;
        mul_b    = {16'd0, first_decay};
        op_neg   = m_old[31];
        op_fresh = 1'b1;
      end
      OP_M_GRAD: begin
        mul_a  = g_abs;
        mul_b  = {15'd0, DECAY_ONE - {1'b0, first_decay}};
        op_neg = grad[31];
      end
      OP_G_SQ: begin mul_a = g_abs; mul_b = g_abs; end
      OP_V_LO: begin
        mul_a    = v_old[31:0];
        mul_b    = {16'd0, second_decay};
        op_fresh = 1'b1;
      end
      OP_V_HI: begin
        mul_a    = {16'd0, v_old[47:32]};
        mul_b    = {16'd0, second_decay};
        op_shift = 1'b1;
      end
      OP_G2_LO: begin
        mul_a = g2[31:0];
        mul_b = {15'd0, DECAY_ONE - {1'b0, second_decay}};
      end
      OP_G2_HI: begin
        mul_a    = {17'd0, g2[46:32]};
        mul_b    = {15'd0, DECAY_ONE - {1'b0, second_decay}};
        op_shift = 1'b1;
      end
      OP_STEP: begin mul_a = mabs; mul_b = {8'd0, learn_rate}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase

    addend  = op_shift ? {prod[35:0], 32'd0} : {4'd0, prod};
    acc_sum = (op_fresh ? 68'd0 : acc) + (op_neg ? (68'd0 - addend) : addend);

    // restoring divider step
    dv_t      = {dv_rem, dv_num[63]};
    dv_ge     = dv_t >= {1'b0, dv_den};
    dv_q_next = {dv_q[46:0], dv_ge};

    // bit-serial square root step
    sq_trial    = sq_res + sq_bit;
    sq_res_next = (sq_x >= sq_trial) ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
    den_calc    = {1'b0, sq_res_next[31:0], 8'd0} + {9'd0, denom_guard};

    vhat     = dv_ovf ? VHAT_MAX : dv_q_next;
    step_num = {prod[55:0], 8'd0};
    step     = (dv_ovf || (dv_q_next[40:0] > STEP_LIMIT)) ? STEP_LIMIT : dv_q_next[40:0];
    res_wide = m_neg ? ({{11{param[31]}}, param} + {2'd0, step})
                     : ({{11{param[31]}}, param} - {2'd0, step});
    slots_sh = 33'(SLOTS) << red_k;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= LEARN_RATE_RESET;
      first_decay  <= FIRST_DECAY_RESET;
      second_decay <= SECOND_DECAY_RESET;
      denom_guard  <= DENOM_GUARD_RESET;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_LEARN_RATE:   learn_rate   <= cfg.data[23:0];
        REG_FIRST_DECAY:  first_decay  <= cfg.data[15:0];
        REG_SECOND_DECAY: second_decay <= cfg.data[15:0];
        REG_DENOM_GUARD:  denom_guard  <= cfg.data;
        default: ;
      endcase
    end
  end

  // moment storage
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_word  <= moment_mem[AW'(red_val)];
      rd_valid <= valid_mem[AW'(red_val)];
    end
    if (state == ST_ACC && op == OP_G2_HI) moment_mem[slot] <= {m_cur, acc_sum[63:16]};
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) valid_mem[clr_cnt] <= 1'b0;
    else if (state == ST_ACC && op == OP_G2_HI) valid_mem[slot] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
    else clr_cnt <= '0;
  end

  // step powers
  always_ff @(posedge clk) begin
    if (rst) begin
      pow1 <= POWER_ONE;
      pow2 <= POWER_ONE;
    end else if (item_fire && action_t'(item.action) == ACT_CLEAR) begin
      pow1 <= POWER_ONE;
      pow2 <= POWER_ONE;
    end else if (state == ST_ACC && op == OP_POW1) begin
      pow1 <= prod[47:16];
    end else if (state == ST_ACC && op == OP_POW2) begin
      pow2 <= prod[47:16];
    end
  end

  // datapath sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        red_val <= item.slot_address;
        red_k   <= REDUCE_TOP;
        param   <= item.param_value;
        grad    <= item.grad_value;
        op      <= item.first_of_call ? OP_POW1 : OP_M_OLD;
      end
      ST_REDUCE: begin
        // slot_address modulo SLOTS by shifted subtraction
        if ({21'd0, red_val} >= slots_sh) red_val <= red_val - slots_sh[11:0];
        red_k <= red_k - 4'd1;
      end
      ST_READ: slot <= AW'(red_val);
      ST_MUL:  prod <= mul_a * mul_b;
      ST_ACC: begin
        acc <= acc_sum;
        op  <= op_t'(op + 4'd1);
        if (op == OP_M_GRAD) m_cur <= acc_sum[47:16];
        if (op == OP_G_SQ) g2 <= prod[62:16];
        if (op == OP_G2_HI) begin
          v_cur  <= acc_sum[63:16];
          dv_ovf <= {1'b0, m_abs} >= d1;
          dv_rem <= {9'd0, m_abs};
          dv_num <= '0;
          dv_den <= {8'd0, d1};
          cnt    <= DIV_M_LAST;
        end
        if (op == OP_STEP) begin
          dv_ovf <= {18'd0, step_num[63:41]} >= den;
          dv_rem <= {18'd0, step_num[63:41]};
          dv_num <= {step_num[40:0], 23'd0};
          dv_den <= den;
          cnt    <= DIV_S_LAST;
        end
      end
      ST_DIV_M, ST_DIV_V, ST_DIV_S: begin
        dv_rem <= dv_ge ? 41'(dv_t - {1'b0, dv_den}) : dv_t[40:0];
        dv_num <= dv_num << 1;
        dv_q   <= dv_q_next;
        cnt    <= cnt - 6'd1;
        if (cnt == '0 && state == ST_DIV_M) begin
          mabs   <= dv_ovf ? MHAT_MAX : dv_q_next[31:0];
          dv_ovf <= {1'b0, v_cur} >= {d2, 16'd0};
          dv_rem <= {9'd0, v_cur[47:16]};
          dv_num <= {v_cur[15:0], 48'd0};
          dv_den <= {8'd0, d2};
          cnt    <= DIV_V_LAST;
        end
        if (cnt == '0 && state == ST_DIV_V) begin
          sq_x   <= {vhat, 16'd0};
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          cnt    <= SQRT_LAST;
        end
        if (cnt == '0 && state == ST_DIV_S) begin
          if (res_wide[42:31] != {12{res_wide[42]}}) begin
            hold_param <= res_wide[42] ? NEG_LIMIT : POS_LIMIT;
            hold_sat   <= 1'b1;
          end else begin
            hold_param <= res_wide[31:0];
            hold_sat   <= 1'b0;
          end
        end
      end
      ST_SQRT: begin
        if (sq_x >= sq_trial) sq_x <= sq_x - sq_trial;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt - 6'd1;
        if (cnt == '0) begin
          den <= (den_calc == '0) ? 41'd1 : den_calc;
          op  <= OP_STEP;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
      out_param <= hold_param;
      out_sat   <= hold_sat;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hdl/adam_chk.sv
`timescale 1ns / 1ps
module adam_chk (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] new_param,
  input logic        saturated
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(new_param) && $stable(saturated))
    else $error("result payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("engine ready right after taking a request");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared one cycle after a request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("engine active right after reset");

endmodule

bind adam_optimizer_update_core adam_chk u_adam_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .new_param    (result.new_param),
  .saturated    (result.saturated)
);
